// File: hdl/icsl_pkg.sv
// Shared constants and types for the streaming Internet checksum block.
package icsl_pkg;

	localparam int BEAT_BYTES = 8;
	localparam int LEN_BITS   = 16;
	localparam int LANES      = (BEAT_BYTES < 8) ? BEAT_BYTES : 8;
	localparam int CNT_W      = $clog2(LANES + 1);
	localparam int SUM_W      = 16 + $clog2(LANES) + 1;
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

	localparam logic [7:0]  MAXUINT8  = 8'hFF;
	localparam logic [15:0] MAXUINT16 = 16'hFFFF;

	typedef logic [15:0] lane_word_t;
	typedef lane_word_t [LANES-1:0] lane_vec_t;

	typedef struct packed {
		logic valid;
		logic first;
		logic last;
	} tag_t;

endpackage

// File: hdl/icsl_if.sv
// Channel interfaces for packet beats and checksum results.
interface icsl_in_if;
	logic        valid;
	logic        ready;
	logic [63:0] data_word;
	logic [3:0]  data_bytes;
	logic        first_beat;
	logic        last_beat;
	logic [15:0] skip_count;
	logic [15:0] sum_length;

	modport source(output valid, data_word, data_bytes, first_beat, last_beat, skip_count,
		sum_length, input ready);
	modport sink(input valid, data_word, data_bytes, first_beat, last_beat, skip_count,
		sum_length, output ready);
endinterface

interface icsl_out_if;
	logic        valid;
	logic        ready;
	logic [15:0] checksum;

	modport source(output valid, checksum, input ready);
	modport sink(input valid, checksum, output ready);
endinterface

// File: hdl/internet_checksum_skip_len.sv
// Top level of the streaming Internet checksum with skip and length counts.
// The block takes one beat of up to eight bytes in every clock cycle while
// input ready is high, and gives one 16-bit checksum per packet. Before a
// checksum appears at the output, the byte lanes and skip and length counters
// are registered at the edge that takes its last beat, then the lane adder,
// and then the four-entry result queue is written. Input ready drops only
// when that queue together with results still in the pipeline holds four
// checksums.
module internet_checksum_skip_len import icsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	icsl_in_if.sink    pkt,
	icsl_out_if.source csum
);

	logic [LEN_BITS-1:0] skip_q;
	logic [LEN_BITS-1:0] len_q;
	logic                odd_q;
	logic [LEN_BITS-1:0] skip_e;
	logic [LEN_BITS-1:0] len_e;
	logic                odd_e;
	logic [CNT_W-1:0]    n_bytes;
	logic [CNT_W-1:0]    n_skip;
	logic [CNT_W-1:0]    n_rem;
	logic [CNT_W-1:0]    n_sum;
	logic                accept;
	lane_vec_t           words;
	lane_vec_t           words_s1;
	tag_t                tag_s1;
	tag_t                tag_s2;
	logic                res_valid;
	logic [15:0]         res_csum;
	logic [FCNT_W-1:0]   fifo_count;
	logic [FCNT_W-1:0]   pending;

	assign accept = pkt.valid && pkt.ready;

	always_comb begin
		skip_e  = pkt.first_beat ? LEN_BITS'(pkt.skip_count) : skip_q;
		len_e   = pkt.first_beat ? LEN_BITS'(pkt.sum_length) : len_q;
		odd_e   = pkt.first_beat ? 1'b0 : odd_q;
		n_bytes = (pkt.data_bytes > 4'(LANES)) ? CNT_W'(LANES) : CNT_W'(pkt.data_bytes);
		n_skip  = (skip_e < LEN_BITS'(n_bytes)) ? skip_e[CNT_W-1:0] : n_bytes;
		n_rem   = n_bytes - n_skip;
		n_sum   = (len_e < LEN_BITS'(n_rem)) ? len_e[CNT_W-1:0] : n_rem;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= '0;
			len_q  <= '0;
			odd_q  <= 1'b0;
		end else if (accept) begin
			skip_q <= skip_e - LEN_BITS'(n_skip);
			len_q  <= len_e - LEN_BITS'(n_sum);
			odd_q  <= odd_e ^ n_sum[0];
		end
	end

	for (genvar i = 0; i < LANES; i++) begin : g_lane
		icsl_lane u_lane (
			.lane_idx  (CNT_W'(i)),
			.lane_byte (pkt.data_word[8*i +: 8]),
			.n_skip    (n_skip),
			.n_sum     (n_sum),
			.odd_start (odd_e),
			.word      (words[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else begin
			tag_s1.valid <= accept;
			tag_s1.first <= pkt.first_beat;
			tag_s1.last  <= pkt.last_beat;
		end
	end

	always_ff @(posedge clk) begin
		words_s1 <= words;
	end

	icsl_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.tag_s1    (tag_s1),
		.words_s1  (words_s1),
		.tag_s2    (tag_s2),
		.res_valid (res_valid),
		.res_csum  (res_csum)
	);

	icsl_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_data (res_csum),
		.count     (fifo_count),
		.csum      (csum)
	);

	assign pending   = FCNT_W'(tag_s1.valid && tag_s1.last) + FCNT_W'(tag_s2.valid && tag_s2.last);
	assign pkt.ready = (fifo_count + pending) < FCNT_W'(FIFO_DEPTH);

endmodule

// File: hdl/icsl_lane.sv
// One byte lane: decides whether its byte is summed and places it in the word.
module icsl_lane import icsl_pkg::*; (
	input  logic [CNT_W-1:0] lane_idx,
	input  logic [7:0]       lane_byte,
	input  logic [CNT_W-1:0] n_skip,
	input  logic [CNT_W-1:0] n_sum,
	input  logic             odd_start,
	output lane_word_t       word
);

	logic [CNT_W-1:0] rel;
	logic             take;
	logic             odd;

	always_comb begin
		rel  = lane_idx - n_skip;
		take = (lane_idx >= n_skip) && (rel < n_sum);
		odd  = odd_start ^ rel[0];
		if (!take) begin
			word = '0;
		end else if (odd) begin
			word = {lane_byte & MAXUINT8, 8'h00};
		end else begin
			word = {8'h00, lane_byte & MAXUINT8};
		end
	end

endmodule

// File: hdl/icsl_merge.sv
// Merging stage: adds the lane words and folds them into the running sum.
module icsl_merge import icsl_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  tag_t       tag_s1,
	input  lane_vec_t  words_s1,
	output tag_t       tag_s2,
	output logic       res_valid,
	output logic [15:0] res_csum
);

	logic [SUM_W-1:0] lane_sum;
	logic [SUM_W-1:0] sum_s2;
	logic [15:0]      acc_q;
	logic [SUM_W-1:0] total;
	logic [16:0]      fold1;
	logic [16:0]      fold2;

	always_comb begin
		lane_sum = '0;
		for (int i = 0; i < LANES; i++) begin
			lane_sum = lane_sum + SUM_W'(words_s1[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s2 <= '0;
		end else begin
			tag_s2 <= tag_s1;
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= lane_sum;
	end

	always_comb begin
		total = (tag_s2.first ? '0 : SUM_W'(acc_q)) + sum_s2;
		fold1 = 17'(total[15:0]) + 17'(total[SUM_W-1:16]);
		fold2 = 17'(fold1[15:0]) + 17'(fold1[16]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
		end else if (tag_s2.valid) begin
			acc_q <= fold2[15:0];
		end
	end

	assign res_valid = tag_s2.valid && tag_s2.last;
	assign res_csum  = (fold2[15:0] == MAXUINT16) ? MAXUINT16 : ~fold2[15:0];

endmodule

// File: hdl/icsl_out_fifo.sv
// Small result queue that decouples the checksum pipeline from the sink.
module icsl_out_fifo import icsl_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [15:0]       push_data,
	output logic [FCNT_W-1:0] count,
	icsl_out_if.source        csum
);

	logic [15:0]      mem [FIFO_DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [FCNT_W-1:0] count_q;
	logic             pop;

	assign pop          = csum.valid && csum.ready;
	assign csum.valid    = (count_q != '0);
	assign csum.checksum = mem[rd_q];
	assign count         = count_q;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_q <= rd_q + PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + FCNT_W'(1);
				2'b01:   count_q <= count_q - FCNT_W'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule
